// ===== rtl/adtd_pkg.sv =====
// ----------------------------------------------------------------------------
// adtd_pkg: shared types and constants of the date adder
// Field widths, calendar constants, controller/datapath command and status
// structs, and the month-length lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package adtd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int ADD_W   = 15;
  localparam int REM_W   = 16;   // day count: 31 + 335 + 32767 fits
  localparam int DIY_W   = 9;    // 365 or 366
  localparam int CENT_W  = 8;    // year / 100, below 164
  localparam int MOD_W   = 7;    // year mod 100

  localparam int IN_DATA_W  = 40;  // 38 field bits, padded to bytes
  localparam int OUT_DATA_W = 24;  // 23 field bits, padded to bytes

  // Division of the year by 100: (year * RECIP_100) >> RECIP_SHIFT
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = 27;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [MOD_W-1:0]  LAST_OF_CENTURY = 7'd99;
  localparam logic [DIY_W-1:0]  DAYS_LEAP_YEAR  = 9'd366;
  localparam logic [DIY_W-1:0]  DAYS_PLAIN_YEAR = 9'd365;
  localparam logic [DAY_W-1:0]  DAYS_FEB_LEAP   = 5'd29;

  typedef logic [DAY_W-1:0] month_len_t [12];

  localparam month_len_t MONTH_LEN = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture an input transfer
    logic init;        // finish year mod 100 and century counters
    logic doy_step;    // add one earlier month to the day count
    logic add_step;    // add the offset, restart month count
    logic year_step;   // remove one whole year
    logic month_step;  // remove one whole month
    logic out_load;    // load the result register
  } adtd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad;         // start month outside 1 to 12
    logic doy_more;    // earlier months still to be counted
    logic year_more;   // count exceeds current year length
    logic month_more;  // count exceeds current month length, before December
  } adtd_stat_t;

  // Length of month m (1 to 12) with the given leap flag
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    len = 5'd0;
    if (m == MONTH_FEB && leap) begin
      len = DAYS_FEB_LEAP;
    end else if (m >= MONTH_JAN && m <= MONTH_DEC) begin
      len = MONTH_LEN[m - MONTH_JAN];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/add_days_to_date_unit.sv =====
// Gregorian date adder. Each input transfer carries a date and a day count;
// one result transfer returns the later date, or zeros with the bad-month
// flag when the month lies outside 1 to 12. Items are handled one at a time:
// an item passes through load and counter setup, the day-of-year loop over
// the months before the start month, the addition of the offset, the year
// loop that removes whole years (about one per 365 days added, up to 90),
// the month loop that removes whole months (up to 11), a closing check for
// each of the year and month loops and the load of the result. A bad month
// skips the loops. The loops share one adder/subtractor. A finished result
// waits in an output register while the next item is taken in; the result
// of that next item is loaded only once the waiting one has been taken.
// ----------------------------------------------------------------------------
// add_days_to_date_unit: date plus day count, top level
// Connects the controller and the datapath to the stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

module add_days_to_date_unit
  import adtd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  // [4:0] start_day, [8:5] start_month, [22:9] start_year, [37:23] days_to_add
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // [4:0] result_day, [8:5] result_month, [22:9] result_year
  output      logic [OUT_DATA_W-1:0] out_tdata,
  // [0] bad_month
  output      logic                  out_tuser
);

  adtd_cmd_t          cmd;
  adtd_stat_t         stat;
  logic [DAY_W-1:0]   res_day;
  logic [MONTH_W-1:0] res_month;
  logic [YEAR_W-1:0]  res_year;
  logic               res_bad;

  adtd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  adtd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_day    (in_tdata[4:0]),
    .in_month  (in_tdata[8:5]),
    .in_year   (in_tdata[22:9]),
    .in_add    (in_tdata[37:23]),
    .res_day   (res_day),
    .res_month (res_month),
    .res_year  (res_year),
    .res_bad   (res_bad)
  );

  // Pack the result fields, pad to whole bytes
  assign out_tdata = {1'b0, res_year, res_month, res_day};
  assign out_tuser = res_bad;

endmodule

`default_nettype wire

// ===== rtl/adtd_dpath.sv =====
// ----------------------------------------------------------------------------
// adtd_dpath: date adder datapath
// Holds the day count, month and year registers with incremental year mod
// 100 and century counters for the leap rule, one shared adder/subtractor,
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module adtd_dpath
  import adtd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire adtd_cmd_t             cmd,
  output      adtd_stat_t            stat,
  input  wire logic [DAY_W-1:0]      in_day,
  input  wire logic [MONTH_W-1:0]    in_month,
  input  wire logic [YEAR_W-1:0]     in_year,
  input  wire logic [ADD_W-1:0]      in_add,
  output      logic [DAY_W-1:0]      res_day,
  output      logic [MONTH_W-1:0]    res_month,
  output      logic [YEAR_W-1:0]     res_year,
  output      logic                  res_bad
);

  logic [REM_W-1:0]   rem_r;
  logic [MONTH_W-1:0] month_r;
  logic [MONTH_W-1:0] m_r;
  logic [YEAR_W-1:0]  year_r;
  logic [ADD_W-1:0]   add_r;
  logic               bad_r;
  logic [CENT_W-1:0]  cent_r;
  logic [MOD_W-1:0]   ymod_r;
  logic [1:0]         cmod_r;

  logic [PROD_W-1:0]  prod;
  logic [YEAR_W:0]    cent_x100;
  logic [YEAR_W:0]    ymod_full;
  logic               leap;
  logic [DAY_W-1:0]   mdays;
  logic [DIY_W-1:0]   ydays;

  // Divide the incoming year by 100 with a reciprocal multiply
  assign prod = PROD_W'(in_year) * PROD_W'(RECIP_100);

  // Remainder of the year by 100 from the registered quotient
  assign cent_x100 = {1'b0, cent_r, 6'd0} + {2'd0, cent_r, 5'd0} + {5'd0, cent_r, 2'd0};
  assign ymod_full = {1'b0, year_r} - cent_x100;

  // Leap rule: divisible by 4, and not a century unless the century is by 4
  assign leap  = (year_r[1:0] == 2'd0) && ((ymod_r != '0) || (cmod_r == 2'd0));
  assign mdays = month_days(m_r, leap);
  assign ydays = leap ? DAYS_LEAP_YEAR : DAYS_PLAIN_YEAR;

  // Report loop conditions
  always_comb begin
    stat.bad        = bad_r;
    stat.doy_more   = (m_r < month_r);
    stat.year_more  = (rem_r > REM_W'(ydays));
    stat.month_more = (m_r < MONTH_DEC) && (rem_r > REM_W'(mdays));
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r   <= REM_W'(in_day);
      month_r <= in_month;
      m_r     <= MONTH_JAN;
      year_r  <= in_year;
      add_r   <= in_add;
      bad_r   <= (in_month < MONTH_JAN) || (in_month > MONTH_DEC);
      cent_r  <= prod[RECIP_SHIFT +: CENT_W];
    end
    if (cmd.init) begin
      ymod_r <= ymod_full[MOD_W-1:0];
      cmod_r <= cent_r[1:0];
    end
    if (cmd.doy_step) begin
      rem_r <= rem_r + REM_W'(mdays);
      m_r   <= m_r + MONTH_W'(1);
    end
    if (cmd.add_step) begin
      rem_r <= rem_r + REM_W'(add_r);
      m_r   <= MONTH_JAN;
    end
    if (cmd.year_step) begin
      rem_r  <= rem_r - REM_W'(ydays);
      year_r <= year_r + YEAR_W'(1);
      // advance the mod 100 and century counters, restart them on wrap
      if (year_r == '1) begin
        ymod_r <= '0;
        cmod_r <= '0;
      end else if (ymod_r == LAST_OF_CENTURY) begin
        ymod_r <= '0;
        cmod_r <= cmod_r + 2'd1;
      end else begin
        ymod_r <= ymod_r + MOD_W'(1);
      end
    end
    if (cmd.month_step) begin
      rem_r <= rem_r - REM_W'(mdays);
      m_r   <= m_r + MONTH_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (bad_r) begin
        res_day   <= '0;
        res_month <= '0;
        res_year  <= '0;
        res_bad   <= 1'b1;
      end else begin
        res_day   <= rem_r[DAY_W-1:0];
        res_month <= m_r;
        res_year  <= year_r;
        res_bad   <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // A good result always lands in a real month
  a_res_month: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (res_bad || (res_month >= MONTH_JAN && res_month <= MONTH_DEC)))
    else $error("result month out of range");

  // The year loop leaves the count within one year
  a_month_fit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.month_step |-> !bad_r && (rem_r <= REM_W'(DAYS_LEAP_YEAR)))
    else $error("month loop entered with more than a year");
`endif

endmodule

`default_nettype wire

// ===== rtl/adtd_ctrl.sv =====
// ----------------------------------------------------------------------------
// adtd_ctrl: date adder controller
// Sequences load, counter setup, day-of-year, year and month loops, and
// owns the input ready and result valid handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module adtd_ctrl
  import adtd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      adtd_cmd_t  cmd,
  input  wire adtd_stat_t stat
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_DOY   = 3'd2;
  localparam logic [2:0] S_YEAR  = 3'd3;
  localparam logic [2:0] S_MONTH = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // Next state, commands and result valid
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        if (stat.bad) begin
          state_nxt = S_DONE;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = S_DOY;
        end
      end
      S_DOY: begin
        if (stat.doy_more) begin
          cmd.doy_step = 1'b1;
        end else begin
          cmd.add_step = 1'b1;
          state_nxt    = S_YEAR;
        end
      end
      S_YEAR: begin
        if (stat.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (stat.month_more) begin
          cmd.month_step = 1'b1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // One item at a time: an accepted transfer closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while busy");

  // A new result appears only out of the done state
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> ($past(state_r) == S_DONE))
    else $error("result valid raised outside done state");

  // The done state never drops a waiting result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while pending");
`endif

endmodule

`default_nettype wire
